>>> src/plc_pkg.sv
// Shared types and constants for the pulse length cluster table.
`timescale 1ns / 1ps
package plc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int HITS_W   = 16;
  localparam int TOTAL_W  = 40;
  localparam int DVD_W    = TOTAL_W + 1;
  localparam int DVS_W    = HITS_W + 1;
  localparam int CNT_OUT_W = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] CFG_ABS_TOL = 2'd0;
  localparam logic [1:0] CFG_REL_TOL = 2'd1;
  localparam logic [1:0] CFG_BUCKET  = 2'd2;

  localparam logic [15:0] ABS_TOL_RST = 16'd100;
  localparam logic [6:0]  REL_TOL_RST = 7'd30;
  localparam logic [15:0] BUCKET_RST  = 16'd100;

  localparam logic [7:0]  PCT_SCALE = 8'd100;
  localparam logic [48:0] PCT_ROUND = 49'd99;

  localparam logic [HITS_W-1:0]   HITS_MAX  = '1;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [19:0]         TOTAL_OUT_MAX = '1;

  typedef struct packed {
    logic [HITS_W-1:0]   hits;
    logic [TOTAL_W-1:0]  total;
    logic [SAMPLE_W-1:0] range_low;
    logic [SAMPLE_W-1:0] range_high;
    logic [SAMPLE_W-1:0] smallest;
    logic [SAMPLE_W-1:0] largest;
  } entry_t;

  typedef enum logic [1:0] {
    WR_HIT,
    WR_NEW,
    WR_MERGE,
    WR_SHIFT
  } wr_sel_t;

  typedef enum logic [1:0] {
    DIV_MERGE,
    DIV_BUCKET,
    DIV_MEAN
  } div_sel_t;

  typedef struct packed {
    logic     cap_in;
    logic     rd_en;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     ld_a;
    logic     ld_b;
    logic     div_start;
    div_sel_t div_sel;
    logic     tol_calc;
    logic     dom_acc;
    logic     dom_first;
    logic     res_load;
    logic     res_zero;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic fit;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> src/plc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module plc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [plc_pkg::DVD_W-1:0]  dividend,
  input  logic [plc_pkg::DVS_W-1:0]  divisor,
  output logic [plc_pkg::DVD_W-1:0]  quotient,
  output logic                       done
);

  localparam int DVD_W = plc_pkg::DVD_W;
  localparam int DVS_W = plc_pkg::DVS_W;
  localparam int CW    = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;

  assign trial = {rem, quotient[DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (cnt != '0) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= DVS_W'(trial - {1'b0, dvs});
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> src/plc_dp.sv
// Datapath: table memory, merge arithmetic, dominant search and result register.
`timescale 1ns / 1ps
module plc_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  plc_pkg::dp_cmd_t                cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   wr_addr,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] res_used,
  output plc_pkg::dp_sts_t                sts,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   best_idx,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic [23:0]                     sample_length,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [23:0]                     dominant_mean,
  output logic [15:0]                     dominant_count,
  output logic [19:0]                     total_count,
  output logic [4:0]                      entries_used
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int HS = plc_pkg::HITS_W + IW + 1;

  plc_pkg::entry_t tbl [TABLE_ENTRIES];
  plc_pkg::entry_t rdata, a_q, b_q, best_q, wdata, merged;

  logic [15:0] abs_tol, bucket;
  logic [6:0]  rel_pct;
  logic [23:0] s_q;
  logic [IW-1:0] rd_idx_q;
  logic [HS-1:0] hsum_q;

  logic [40:0] nsum, dvd, quot;
  logic [16:0] ncnt, dvs;
  logic        div_done;
  logic [15:0] bw_eff;

  logic [41:0] ahi_q;
  logic [40:0] alo_q;
  logic [48:0] rhi_q, rlo_q;
  logic [23:0] mn, mx;
  logic [30:0] mn100, mx100;
  logic [40:0] hit_total;
  logic [39:0] new_lo_full;
  logic [24:0] new_hi_sum;
  logic [CW+4:0] used_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_tol <= plc_pkg::ABS_TOL_RST;
      rel_pct <= plc_pkg::REL_TOL_RST;
      bucket  <= plc_pkg::BUCKET_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        plc_pkg::CFG_ABS_TOL: abs_tol <= cfg_data;
        plc_pkg::CFG_REL_TOL: rel_pct <= cfg_data[6:0];
        plc_pkg::CFG_BUCKET:  bucket  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) s_q <= sample_length;
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) tbl[wr_addr] <= wdata;
    if (cmd.rd_en) begin
      rdata    <= tbl[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  assign bw_eff = (bucket == '0) ? 16'd1 : bucket;
  assign nsum   = {1'b0, a_q.total} + {1'b0, b_q.total};
  assign ncnt   = {1'b0, a_q.hits} + {1'b0, b_q.hits};
  assign mn     = (a_q.smallest < b_q.smallest) ? a_q.smallest : b_q.smallest;
  assign mx     = (a_q.largest > b_q.largest) ? a_q.largest : b_q.largest;

  always_comb begin
    dvd = nsum;
    dvs = (ncnt == '0) ? 17'd1 : ncnt;
    case (cmd.div_sel)
      plc_pkg::DIV_BUCKET: begin
        dvd = {17'b0, s_q};
        dvs = {1'b0, bw_eff};
      end
      plc_pkg::DIV_MEAN: begin
        dvd = {1'b0, best_q.total};
        dvs = (best_q.hits == '0) ? 17'd1 : {1'b0, best_q.hits};
      end
      default: ;
    endcase
  end

  plc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quot),
    .done     (div_done)
  );

  // tolerance bounds around the merged mean
  always_ff @(posedge clk) begin
    if (cmd.tol_calc) begin
      ahi_q <= {1'b0, quot} + {26'b0, abs_tol};
      alo_q <= (quot > {25'b0, abs_tol}) ? quot - {25'b0, abs_tol} : '0;
      rhi_q <= {8'b0, quot} * {41'b0, plc_pkg::PCT_SCALE + {1'b0, rel_pct}};
      rlo_q <= ({1'b0, rel_pct} < plc_pkg::PCT_SCALE)
             ? {8'b0, quot} * {41'b0, plc_pkg::PCT_SCALE - {1'b0, rel_pct}} : '0;
    end
  end

  assign mn100 = {7'b0, mn} * 31'd100;
  assign mx100 = {7'b0, mx} * 31'd100;

  always_comb begin
    merged            = a_q;
    merged.total      = nsum[40] ? plc_pkg::TOTAL_MAX : nsum[39:0];
    merged.hits       = ncnt[16] ? plc_pkg::HITS_MAX : ncnt[15:0];
    merged.range_high = (a_q.range_high > b_q.range_high) ? a_q.range_high : b_q.range_high;
    merged.range_low  = (a_q.range_low < b_q.range_low) ? a_q.range_low : b_q.range_low;
    merged.smallest   = mn;
    merged.largest    = mx;
  end

  assign hit_total   = {1'b0, rdata.total} + {17'b0, s_q};
  assign new_lo_full = quot[23:0] * {8'b0, bw_eff};
  assign new_hi_sum  = {1'b0, new_lo_full[23:0]} + {9'b0, bw_eff} - 25'd1;

  always_comb begin
    wdata = rdata;
    case (cmd.wr_sel)
      plc_pkg::WR_HIT: begin
        wdata.hits     = (rdata.hits == plc_pkg::HITS_MAX) ? rdata.hits : rdata.hits + 1'b1;
        wdata.total    = hit_total[40] ? plc_pkg::TOTAL_MAX : hit_total[39:0];
        wdata.smallest = (s_q < rdata.smallest) ? s_q : rdata.smallest;
        wdata.largest  = (s_q > rdata.largest) ? s_q : rdata.largest;
      end
      plc_pkg::WR_NEW: begin
        wdata.hits       = 16'd1;
        wdata.total      = {16'b0, s_q};
        wdata.range_low  = new_lo_full[23:0];
        wdata.range_high = new_hi_sum[24] ? plc_pkg::SAMPLE_MAX : new_hi_sum[23:0];
        wdata.smallest   = s_q;
        wdata.largest    = s_q;
      end
      plc_pkg::WR_MERGE: wdata = merged;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_a) a_q <= rdata;
    else if (cmd.wr_en && cmd.wr_sel == plc_pkg::WR_MERGE) a_q <= merged;
    if (cmd.ld_b) b_q <= rdata;
  end

  // dominant search: keep the earliest entry with the greatest count
  always_ff @(posedge clk) begin
    if (cmd.dom_acc) begin
      if (cmd.dom_first || rdata.hits > best_q.hits) begin
        best_q   <= rdata;
        best_idx <= rd_idx_q;
      end
      if (cmd.dom_first) hsum_q <= HS'(rdata.hits);
      else               hsum_q <= hsum_q + HS'(rdata.hits);
    end
  end

  assign used_ext = {5'b0, res_used};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status       <= cmd.res_status;
      entries_used <= used_ext[4:0];
      if (cmd.res_zero) begin
        dominant_mean  <= '0;
        dominant_count <= '0;
        total_count    <= '0;
      end else begin
        dominant_mean  <= (quot[40:24] != '0) ? plc_pkg::SAMPLE_MAX : quot[23:0];
        dominant_count <= best_q.hits;
        total_count    <= (hsum_q > HS'(plc_pkg::TOTAL_OUT_MAX))
                        ? plc_pkg::TOTAL_OUT_MAX : 20'(hsum_q);
      end
    end
  end

  assign sts.hit      = (rdata.range_low <= s_q) && (s_q <= rdata.range_high);
  assign sts.fit      = (({18'b0, mx} <= ahi_q) && ({17'b0, mn} >= alo_q))
                     || (({18'b0, mx100} <= rhi_q)
                         && (rlo_q <= {18'b0, mn100} + plc_pkg::PCT_ROUND));
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

>>> src/plc_ctrl.sv
// Controller: sequences insert, merge pass, dominant search, remove and clear.
`timescale 1ns / 1ps
module plc_ctrl #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  plc_pkg::dp_sts_t                  sts,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   best_idx,
  output plc_pkg::dp_cmd_t                  cmd,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   wr_addr,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] res_used
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_SCAN, S_INS_NEW, S_INS_DIV, S_INS_WR,
    S_MRG_START, S_M_LDA, S_M_LDB, S_M_DIVS, S_M_DIV, S_M_TEST,
    S_SHIFT, S_M_NEXTB, S_DOM_START, S_DOM_SCAN, S_DOM_DIVS, S_DOM_DIV, S_RES
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] used, used_next, k, k_next, a, a_next, b, b_next, j, j_next;
  logic [1:0] op_q, op_next, st_q, st_next;
  logic rm_q, rm_next;
  logic [CW:0] k_p1, a_p1, a_p2, b_p1, j_p1, j_p2, used_w, best_p1;

  assign k_p1    = {1'b0, k} + 1'b1;
  assign a_p1    = {1'b0, a} + 1'b1;
  assign a_p2    = {1'b0, a} + 2'd2;
  assign b_p1    = {1'b0, b} + 1'b1;
  assign j_p1    = {1'b0, j} + 1'b1;
  assign j_p2    = {1'b0, j} + 2'd2;
  assign used_w  = {1'b0, used};
  assign best_p1 = (CW + 1)'(best_idx) + 1'b1;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    used_next  = used;
    k_next = k;
    a_next = a;
    b_next = b;
    j_next = j;
    op_next = op_q;
    st_next = st_q;
    rm_next = rm_q;
    cmd = '0;
    cmd.wr_sel  = plc_pkg::WR_SHIFT;
    cmd.div_sel = plc_pkg::DIV_MERGE;
    rd_addr  = '0;
    wr_addr  = '0;
    res_used = used;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          op_next = opcode;
          st_next = plc_pkg::ST_OK;
          case (opcode)
            plc_pkg::OP_INSERT: begin
              k_next = '0;
              if (used == '0) begin
                state_next = S_INS_NEW;
              end else begin
                cmd.rd_en  = 1'b1;
                state_next = S_INS_SCAN;
              end
            end
            plc_pkg::OP_CLEAR: begin
              used_next  = '0;
              state_next = S_RES;
            end
            default: state_next = S_DOM_START;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (sts.hit) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = plc_pkg::WR_HIT;
          wr_addr    = IW'(k);
          state_next = S_MRG_START;
        end else if (k_p1 < used_w) begin
          cmd.rd_en = 1'b1;
          rd_addr   = IW'(k_p1);
          k_next    = CW'(k_p1);
        end else if (used_w < (CW + 1)'(TABLE_ENTRIES)) begin
          state_next = S_INS_NEW;
        end else begin
          st_next    = plc_pkg::ST_FULL;
          state_next = S_MRG_START;
        end
      end
      S_INS_NEW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = plc_pkg::DIV_BUCKET;
        state_next    = S_INS_DIV;
      end
      S_INS_DIV: begin
        cmd.div_sel = plc_pkg::DIV_BUCKET;
        if (sts.div_done) state_next = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = plc_pkg::WR_NEW;
        wr_addr    = IW'(used);
        used_next  = CW'(used_w + 1'b1);
        state_next = S_MRG_START;
      end
      S_MRG_START: begin
        a_next = '0;
        if (used_w >= (CW + 1)'(2)) begin
          cmd.rd_en  = 1'b1;
          state_next = S_M_LDA;
        end else begin
          state_next = S_DOM_START;
        end
      end
      S_M_LDA: begin
        cmd.ld_a   = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = IW'(a_p1);
        b_next     = CW'(a_p1);
        state_next = S_M_LDB;
      end
      S_M_LDB: begin
        cmd.ld_b   = 1'b1;
        state_next = S_M_DIVS;
      end
      S_M_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_M_DIV;
      end
      S_M_DIV: begin
        if (sts.div_done) begin
          cmd.tol_calc = 1'b1;
          state_next   = S_M_TEST;
        end
      end
      S_M_TEST: begin
        if (sts.fit) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = plc_pkg::WR_MERGE;
          wr_addr    = IW'(a);
          j_next     = b;
          rm_next    = 1'b0;
          if (b_p1 < used_w) begin
            cmd.rd_en  = 1'b1;
            rd_addr    = IW'(b_p1);
            state_next = S_SHIFT;
          end else begin
            used_next  = CW'(used_w - 1'b1);
            state_next = S_M_NEXTB;
          end
        end else begin
          b_next     = CW'(b_p1);
          state_next = S_M_NEXTB;
        end
      end
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = plc_pkg::WR_SHIFT;
        wr_addr    = IW'(j);
        j_next     = CW'(j_p1);
        if (j_p2 < used_w) begin
          cmd.rd_en = 1'b1;
          rd_addr   = IW'(j_p2);
        end else begin
          used_next  = CW'(used_w - 1'b1);
          state_next = rm_q ? S_IDLE : S_M_NEXTB;
        end
      end
      S_M_NEXTB: begin
        if ({1'b0, b} < used_w) begin
          cmd.rd_en  = 1'b1;
          rd_addr    = IW'(b);
          state_next = S_M_LDB;
        end else if (a_p2 < used_w) begin
          a_next     = CW'(a_p1);
          cmd.rd_en  = 1'b1;
          rd_addr    = IW'(a_p1);
          state_next = S_M_LDA;
        end else begin
          state_next = S_DOM_START;
        end
      end
      S_DOM_START: begin
        k_next = '0;
        if (used == '0) begin
          state_next = S_RES;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_DOM_SCAN;
        end
      end
      S_DOM_SCAN: begin
        cmd.dom_acc   = 1'b1;
        cmd.dom_first = (k == '0);
        if (k_p1 < used_w) begin
          cmd.rd_en = 1'b1;
          rd_addr   = IW'(k_p1);
          k_next    = CW'(k_p1);
        end else begin
          state_next = S_DOM_DIVS;
        end
      end
      S_DOM_DIVS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = plc_pkg::DIV_MEAN;
        state_next    = S_DOM_DIV;
      end
      S_DOM_DIV: begin
        cmd.div_sel = plc_pkg::DIV_MEAN;
        if (sts.div_done) state_next = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
          if (op_q == plc_pkg::OP_CLEAR) begin
            cmd.res_zero   = 1'b1;
            cmd.res_status = plc_pkg::ST_OK;
          end else if (used == '0) begin
            cmd.res_zero   = 1'b1;
            cmd.res_status = plc_pkg::ST_EMPTY;
          end else if (op_q == plc_pkg::OP_REMOVE) begin
            cmd.res_status = plc_pkg::ST_OK;
            res_used = CW'(used_w - 1'b1);
            j_next   = CW'(best_idx);
            rm_next  = 1'b1;
            if (best_p1 < used_w) begin
              cmd.rd_en  = 1'b1;
              rd_addr    = IW'(best_p1);
              state_next = S_SHIFT;
            end else begin
              used_next = CW'(used_w - 1'b1);
            end
          end else begin
            cmd.res_status = (op_q == plc_pkg::OP_INSERT) ? st_q : plc_pkg::ST_OK;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      k <= '0;
      a <= '0;
      b <= '0;
      j <= '0;
      op_q <= plc_pkg::OP_INSERT;
      st_q <= plc_pkg::ST_OK;
      rm_q <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      k <= k_next;
      a <= a_next;
      b <= b_next;
      j <= j_next;
      op_q <= op_next;
      st_q <= st_next;
      rm_q <= rm_next;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, used} <= (CW + 1)'(TABLE_ENTRIES))
    else $error("entry count beyond table depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && cmd.rd_en && wr_addr == rd_addr))
    else $error("read and write to the same entry in one cycle");

  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done right after start");

endmodule

>>> src/pulse_length_cluster_table_core.sv
// Top level of the pulse length cluster table.
//
// Usage: each input transaction carries an opcode (insert, query dominant,
// remove dominant, clear) and a sample length in microseconds. Every input
// transaction yields exactly one output transaction with status, dominant
// mean and count, total count and the number of entries in use.
// The configuration port writes abs_tolerance (index 0), rel_tolerance_pct
// (index 1) and bucket_width (index 2); the user must write it only while
// the block is idle, which the block itself does not enforce.
// Rate: one transaction at a time. Query time for N valid entries is set
// by the table scan and the serial divider; remove closes the gap after
// its result. Insert adds a scan of up to N reads, a bucket division when
// a new entry opens, and one merge pass, with one division per compared
// entry pair and one write per shifted entry, set by the table memory and
// the shared divider.
// Reset clears the entry count and loads the default tolerances; the table
// memory itself is not cleared. When the receiver stalls, the result holds
// in the output register; the block still takes the next transaction and
// waits before loading its result until the old one is taken.
`timescale 1ns / 1ps
module pulse_length_cluster_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [23:0] sample_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [23:0] dominant_mean,
  output logic [15:0] dominant_count,
  output logic [19:0] total_count,
  output logic [4:0]  entries_used,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  plc_pkg::dp_cmd_t cmd;
  plc_pkg::dp_sts_t sts;
  logic [IW-1:0] rd_addr, wr_addr, best_idx;
  logic [CW-1:0] res_used;

  // sequencer: owns the entry count and all table indexes
  plc_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .sts      (sts),
    .best_idx (best_idx),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .res_used (res_used)
  );

  // table, arithmetic, configuration and output register
  plc_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .res_used       (res_used),
    .sts            (sts),
    .best_idx       (best_idx),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_length  (sample_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .dominant_mean  (dominant_mean),
    .dominant_count (dominant_count),
    .total_count    (total_count),
    .entries_used   (entries_used)
  );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the pulse length cluster table core.
`timescale 1ns / 1ps
module tb;

  localparam int ENTRIES = 16;
  localparam int IDLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 3000;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] length;
  } pulse_op_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [23:0] mean;
    logic [15:0] dom_cnt;
    logic [19:0] total;
    logic [4:0]  used;
  } table_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = plc_pkg::OP_QUERY;
  logic [23:0] sample_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [23:0] dominant_mean;
  logic [15:0] dominant_count;
  logic [19:0] total_count;
  logic [4:0] entries_used;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = plc_pkg::CFG_ABS_TOL;
  logic [15:0] cfg_data = '0;

  pulse_length_cluster_table_core #(.TABLE_ENTRIES(ENTRIES)) DUT (.*);

  always #6 clk = ~clk;

  // Shadow table and registers
  logic [63:0] sh_hits [ENTRIES];
  logic [63:0] sh_sum [ENTRIES];
  logic [63:0] sh_lo [ENTRIES];
  logic [63:0] sh_hi [ENTRIES];
  logic [63:0] sh_min [ENTRIES];
  logic [63:0] sh_max [ENTRIES];
  int unsigned sh_used;
  logic [63:0] tol_abs, tol_pct, bucket;

  pulse_op_t pending_ops[$];
  table_report_t expected_reports[$];
  int unsigned mismatches = 0;
  int unsigned reports_seen = 0;
  int unsigned ops_sent = 0;
  int unsigned full_drops = 0;
  int unsigned idle_cycles = 0;
  bit feed_hold = 1'b0;
  bit long_stall_req = 1'b0;
  bit in_accepted = 1'b0;

  function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
    return a < b ? a : b;
  endfunction

  function automatic logic [63:0] max64(logic [63:0] a, logic [63:0] b);
    return a > b ? a : b;
  endfunction

  // Remove entry k and close the gap
  function automatic void shift_out(int unsigned k);
    for (int unsigned j = k; j + 1 < sh_used; j++) begin
      sh_hits[j] = sh_hits[j+1]; sh_sum[j] = sh_sum[j+1];
      sh_lo[j] = sh_lo[j+1]; sh_hi[j] = sh_hi[j+1];
      sh_min[j] = sh_min[j+1]; sh_max[j] = sh_max[j+1];
    end
    if (sh_used > 0) sh_used--;
  endfunction

  function automatic void merge_clusters();
    int unsigned a, b;
    logic [63:0] nsum, ncnt, m, ahi, alo, rhi, rlo, mn, mx;
    for (a = 0; a < sh_used; a++) begin
      b = a + 1;
      while (b < sh_used) begin
        nsum = sh_sum[a] + sh_sum[b];
        ncnt = sh_hits[a] + sh_hits[b];
        if (ncnt == 0) ncnt = 1;
        m = nsum / ncnt;
        ahi = m + tol_abs;
        alo = m > tol_abs ? m - tol_abs : 0;
        rhi = m * (100 + tol_pct) / 100;
        rlo = tol_pct < 100 ? m * (100 - tol_pct) / 100 : 0;
        mn = min64(sh_min[a], sh_min[b]);
        mx = max64(sh_max[a], sh_max[b]);
        if ((mx <= ahi && mn >= alo) || (mx <= rhi && mn >= rlo)) begin
          sh_sum[a] = min64(nsum, 64'hFF_FFFF_FFFF);
          sh_hits[a] = min64(ncnt, 64'hFFFF);
          sh_hi[a] = max64(sh_hi[a], sh_hi[b]);
          sh_lo[a] = min64(sh_lo[a], sh_lo[b]);
          sh_min[a] = mn;
          sh_max[a] = mx;
          shift_out(b);
        end else begin
          b++;
        end
      end
    end
  endfunction

  function automatic table_report_t summarize(logic [1:0] st, bit have);
    table_report_t r;
    int unsigned best;
    logic [63:0] tot, h;
    r = '0;
    r.st = st;
    best = 0;
    tot = 0;
    if (have && sh_used > 0) begin
      for (int unsigned k = 0; k < sh_used; k++) begin
        if (sh_hits[k] > sh_hits[best]) best = k;
        tot += sh_hits[k];
      end
      h = sh_hits[best] ? sh_hits[best] : 1;
      r.mean = min64(sh_sum[best] / h, 64'hFF_FFFF);
      r.dom_cnt = sh_hits[best][15:0];
      r.total = min64(tot, 64'hF_FFFF);
    end
    r.used = sh_used[4:0];
    return r;
  endfunction

  function automatic table_report_t cluster_table_step(pulse_op_t t);
    table_report_t r;
    logic [63:0] s, bw, lo;
    logic [1:0] st;
    bit placed;
    int unsigned best;
    s = {40'd0, t.length};
    case (t.op)
      plc_pkg::OP_INSERT: begin
        placed = 1'b0;
        st = plc_pkg::ST_OK;
        for (int unsigned k = 0; k < sh_used && !placed; k++) begin
          if (sh_lo[k] <= s && s <= sh_hi[k]) begin
            sh_hits[k] = min64(sh_hits[k] + 1, 64'hFFFF);
            sh_sum[k] = min64(sh_sum[k] + s, 64'hFF_FFFF_FFFF);
            sh_min[k] = min64(sh_min[k], s);
            sh_max[k] = max64(sh_max[k], s);
            placed = 1'b1;
          end
        end
        if (!placed) begin
          if (sh_used < ENTRIES) begin
            bw = bucket ? bucket : 1;
            lo = s / bw * bw;
            sh_hits[sh_used] = 1; sh_sum[sh_used] = s;
            sh_lo[sh_used] = lo;
            sh_hi[sh_used] = min64(lo + bw - 1, 64'hFF_FFFF);
            sh_min[sh_used] = s; sh_max[sh_used] = s;
            sh_used++;
          end else begin
            st = plc_pkg::ST_FULL;
            full_drops++;
          end
        end
        merge_clusters();
        r = summarize(st, sh_used > 0);
      end
      plc_pkg::OP_QUERY:
        r = summarize(sh_used > 0 ? plc_pkg::ST_OK : plc_pkg::ST_EMPTY, sh_used > 0);
      plc_pkg::OP_REMOVE: begin
        if (sh_used == 0) begin
          r = summarize(plc_pkg::ST_EMPTY, 1'b0);
        end else begin
          r = summarize(plc_pkg::ST_OK, 1'b1);
          best = 0;
          for (int unsigned k = 0; k < sh_used; k++)
            if (sh_hits[k] > sh_hits[best]) best = k;
          shift_out(best);
          r.used = sh_used[4:0];
        end
      end
      default: begin
        sh_used = 0;
        r = summarize(plc_pkg::ST_OK, 1'b0);
      end
    endcase
    return r;
  endfunction

  // Gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Driver: change inputs on the falling edge, hold until accepted
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // hold the offered transaction
    end else begin
      if (in_accepted) send_gap = pick_gap();
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0 && !feed_hold) begin
        pulse_op_t t;
        t = pending_ops.pop_front();
        opcode <= t.op;
        sample_length <= t.length;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure, with one long hold-off on request
  int unsigned stall_left = 0;
  always @(negedge clk) begin
    if (long_stall_req && stall_left == 0) begin
      stall_left = 2000;
      long_stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 9) != 0);
    end
  end

  // Monitor: predict on accepted input, check on accepted output
  always @(posedge clk) begin
    in_accepted = !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(cluster_table_step('{op: opcode, length: sample_length}));
        ops_sent++;
      end
      if (out_valid && !out_stall) begin
        table_report_t got, want;
        got = '{st: status, mean: dominant_mean, dom_cnt: dominant_count,
                total: total_count, used: entries_used};
        reports_seen++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result %p", got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected %p got %p", reports_seen, want, got);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", expected_reports.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic queue_op(logic [1:0] op, logic [23:0] len);
    pending_ops.push_back('{op: op, length: len});
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Write one register while idle, mirror it in the shadow copy
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      plc_pkg::CFG_ABS_TOL: tol_abs = {48'd0, val};
      plc_pkg::CFG_REL_TOL: tol_pct = {57'd0, val[6:0]};
      default: bucket = {48'd0, val};
    endcase
  endtask

  // Realistic IR timings clustered around a few centers, plus noise
  function automatic logic [23:0] pulse_len(int unsigned centers_sel);
    int unsigned c;
    c = centers_sel % 4;
    case (c)
      0: return 24'(560 + $urandom_range(0, 120) - 60);
      1: return 24'(1690 + $urandom_range(0, 200) - 100);
      2: return 24'(9000 + $urandom_range(0, 400) - 200);
      default: return $urandom_range(0, 99) < 10 ? 24'($urandom) : 24'($urandom_range(0, 20000));
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned p;
    for (int unsigned i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 75) queue_op(plc_pkg::OP_INSERT, pulse_len($urandom));
      else if (p < 87) queue_op(plc_pkg::OP_QUERY, 24'($urandom));
      else if (p < 97) queue_op(plc_pkg::OP_REMOVE, 24'($urandom));
      else queue_op(plc_pkg::OP_CLEAR, 24'($urandom));
    end
  endtask

  initial begin
    tol_abs = 100;
    tol_pct = 30;
    bucket = 100;
    sh_used = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table cases and extreme sample lengths
    queue_op(plc_pkg::OP_QUERY, 24'd0);
    queue_op(plc_pkg::OP_REMOVE, 24'hFFFFFF);
    queue_op(plc_pkg::OP_INSERT, 24'd0);
    queue_op(plc_pkg::OP_INSERT, 24'hFFFFFF);
    queue_op(plc_pkg::OP_INSERT, 24'hAAAAAA);
    queue_op(plc_pkg::OP_INSERT, 24'h555555);
    queue_op(plc_pkg::OP_QUERY, 24'd0);
    queue_op(plc_pkg::OP_REMOVE, 24'd0);
    queue_op(plc_pkg::OP_CLEAR, 24'd0);
    wait_drained();

    // Fill the table with far-apart samples, then overflow it
    write_reg(plc_pkg::CFG_ABS_TOL, 16'd0);
    write_reg(plc_pkg::CFG_REL_TOL, 16'd0);
    write_reg(plc_pkg::CFG_BUCKET, 16'd1);
    for (int unsigned k = 0; k < 18; k++) queue_op(plc_pkg::OP_INSERT, 24'(k * 1000 + 7));
    queue_op(plc_pkg::OP_REMOVE, 24'd0);
    wait_drained();

    // Zero bucket width, relative tolerance above 100, widest tolerances
    write_reg(plc_pkg::CFG_BUCKET, 16'd0);
    write_reg(plc_pkg::CFG_REL_TOL, 16'd127);
    queue_op(plc_pkg::OP_INSERT, 24'd3);
    queue_op(plc_pkg::OP_CLEAR, 24'd0);
    wait_drained();
    write_reg(plc_pkg::CFG_ABS_TOL, 16'hFFFF);
    write_reg(plc_pkg::CFG_BUCKET, 16'hFFFF);
    write_reg(plc_pkg::CFG_REL_TOL, 16'd100);
    queue_op(plc_pkg::OP_INSERT, 24'hFFFFF0);
    queue_op(plc_pkg::OP_INSERT, 24'd10);
    random_phase(150);

    // Receiver holds off while the sender keeps offering
    long_stall_req = 1'b1;
    wait_drained();

    // Default settings, then a tight and a wide setting
    write_reg(plc_pkg::CFG_ABS_TOL, 16'd100);
    write_reg(plc_pkg::CFG_REL_TOL, 16'd30);
    write_reg(plc_pkg::CFG_BUCKET, 16'd100);
    random_phase(300);
    // pause the sender midway until every expected result is back
    while (pending_ops.size() > 150) @(posedge clk);
    feed_hold = 1'b1;
    while (in_valid || expected_reports.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    feed_hold = 1'b0;
    wait_drained();
    write_reg(plc_pkg::CFG_ABS_TOL, 16'd20);
    write_reg(plc_pkg::CFG_REL_TOL, 16'd5);
    write_reg(plc_pkg::CFG_BUCKET, 16'd50);
    random_phase(250);
    wait_drained();
    write_reg(plc_pkg::CFG_ABS_TOL, 16'd500);
    write_reg(plc_pkg::CFG_REL_TOL, 16'd60);
    write_reg(plc_pkg::CFG_BUCKET, 16'd1000);
    random_phase(220);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions, %0d results, %0d table-full drops",
             ops_sent, reports_seen, full_drops);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_reports.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/plc_pkg.sv
src/plc_div.sv
src/plc_dp.sv
src/plc_ctrl.sv
src/pulse_length_cluster_table_core.sv
verif/tb.sv
